/* sv/pkec_pkg.sv */
`timescale 1ns / 1ps
// Package: key word widths, direction pair masks and the pair cancellation function.
package pkec_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned SLOT_W = 4;

  localparam logic [KEY_W-1:0] PAIR_LR    = 16'h0030;
  localparam logic [KEY_W-1:0] PAIR_UD    = 16'h00c0;
  localparam logic [KEY_W-1:0] COMBO_KEYS = 16'h030c;

  typedef logic [KEY_W-1:0] keys_t;

  // Clear a direction pair when both of its keys are held; pairs are independent.
  function automatic keys_t cancel_pairs(input keys_t raw);
    keys_t k;
    k = raw;
    if ((k & PAIR_LR) == PAIR_LR) begin
      k = k & ~PAIR_LR;
    end
    if ((k & PAIR_UD) == PAIR_UD) begin
      k = k & ~PAIR_UD;
    end
    return k;
  endfunction

endpackage

/* sv/pad_keys_edge_conditioner_core.sv */
`timescale 1ns / 1ps
// Pad key conditioner: opposing-pair cancellation, per-slot press/release edges, frame combo flag.
// Takes one item per clock when the output side keeps up. An accepted item issues its read
// of the per-slot previous-key memory at once, is evaluated in the next cycle as the read
// data returns, and moves from the evaluate stage into the output register once the output
// side can take it; its result is offered there until taken. Each item makes a single
// read-modify-write of its slot's word; a read that overlaps the write-back of the item
// just ahead on the same slot takes the forwarded word. Up to two items are in flight.
// Reset clears the store through one valid bit per slot, so the block is ready in the
// cycle after reset with no clearing pass.
module pad_keys_edge_conditioner_core #(
  parameter int unsigned PLAYER_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         frame_start,
  input  logic [pkec_pkg::SLOT_W-1:0]  slot,
  input  logic [pkec_pkg::KEY_W-1:0]   raw_keys,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pkec_pkg::SLOT_W-1:0]  slot_out,
  output logic [pkec_pkg::KEY_W-1:0]   current_keys,
  output logic [pkec_pkg::KEY_W-1:0]   pressed_keys,
  output logic [pkec_pkg::KEY_W-1:0]   released_keys,
  output logic                         combo_flag
);

  localparam int unsigned AW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;

  pkec_pkg::keys_t mem [PLAYER_SLOTS];
  logic [PLAYER_SLOTS-1:0] vld;

  // evaluate stage
  logic                        s1_valid;
  logic                        s1_start;
  logic [pkec_pkg::SLOT_W-1:0] s1_slot;
  logic [AW-1:0]               s1_idx;
  logic                        s1_in_range;
  pkec_pkg::keys_t             s1_keys;
  logic                        s1_vld;
  logic                        s1_fwd;
  pkec_pkg::keys_t             s1_fwd_data;
  pkec_pkg::keys_t             rdata;

  logic                        combo;
  logic                        combo_next;

  logic                        in_acc;
  logic                        s1_adv;
  logic [AW-1:0]               in_idx;
  logic                        in_in_range;
  pkec_pkg::keys_t             old_keys;
  pkec_pkg::keys_t             changed;

  assign in_idx      = AW'(slot);
  assign in_in_range = (32'(slot) < PLAYER_SLOTS);
  assign s1_adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !s1_valid || s1_adv;
  assign in_acc      = in_valid && in_ready;

  always_comb begin
    if (!s1_in_range) begin
      old_keys = '0;
    end else if (s1_fwd) begin
      old_keys = s1_fwd_data;
    end else if (s1_vld) begin
      old_keys = rdata;
    end else begin
      old_keys = '0;
    end
    changed    = s1_keys ^ old_keys;
    combo_next = (s1_start ? 1'b0 : combo) || (s1_keys == pkec_pkg::COMBO_KEYS);
  end

  // memory read at acceptance, write-back as the item leaves the evaluate stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdata <= mem[in_idx];
    end
    if (s1_adv && s1_in_range) begin
      mem[s1_idx] <= s1_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (s1_adv && s1_in_range) begin
      vld[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start    <= frame_start;
      s1_slot     <= slot;
      s1_idx      <= in_idx;
      s1_in_range <= in_in_range;
      s1_keys     <= pkec_pkg::cancel_pairs(raw_keys);
      s1_vld      <= vld[in_idx];
      // the item ahead writes this slot on the same edge as the read
      s1_fwd      <= s1_adv && s1_in_range && (s1_idx == in_idx);
      s1_fwd_data <= s1_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combo     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        combo     <= combo_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      slot_out      <= s1_slot;
      current_keys  <= s1_keys;
      pressed_keys  <= s1_keys & changed;
      released_keys <= old_keys & changed;
      combo_flag    <= combo_next;
    end
  end

  a_fwd_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> s1_in_range)
    else $error("forwarded word on an out-of-range slot");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pressed_keys & released_keys) == '0))
    else $error("key both pressed and released");

  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pressed_keys & ~current_keys) == '0))
    else $error("pressed key not in current keys");

  a_combo_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && (current_keys == pkec_pkg::COMBO_KEYS) |-> combo_flag)
    else $error("combo word without combo flag");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("item in flight after reset");

endmodule
